>>> hdl/dtt_pkg.sv
// dtt_pkg: shared types and constants for the deadline timer table.
// No dependencies.
package dtt_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned TimeW = 48;
  localparam int unsigned DurW = 32;
  localparam int unsigned WaiterW = 16;
  localparam int unsigned DelayW = 49;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_FIRE   = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_FIRED     = 3'd0,
    KIND_IMMEDIATE = 3'd1,
    KIND_ARMED     = 3'd2,
    KIND_FULL      = 3'd3,
    KIND_CANCELLED = 3'd4,
    KIND_DELAY     = 3'd5,
    KIND_NONE_DUE  = 3'd6
  } kind_e;

  // classified command handed from the front end to the engine
  typedef struct packed {
    action_e              action;
    logic [TimeW-1:0]     now_ms;
    logic                 dur_pos;
    logic [TimeW-1:0]     deadline;
    logic [WaiterW-1:0]   waiter;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CANCEL,
    ST_FIRE,
    ST_QUERY,
    ST_EMIT
  } eng_state_e;

endpackage

>>> hdl/dtt_if.sv
// dtt_if: valid/ready channel interfaces for request and result.
// Depends on dtt_pkg.
interface dtt_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [dtt_pkg::TimeW-1:0]    now_ms;
  logic signed [dtt_pkg::DurW-1:0] duration_ms;
  logic [dtt_pkg::WaiterW-1:0]  waiter_id;
  modport source (output valid, action, now_ms, duration_ms, waiter_id, input ready);
  modport sink (input valid, action, now_ms, duration_ms, waiter_id, output ready);
endinterface

interface dtt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    kind;
  logic [dtt_pkg::WaiterW-1:0]   out_waiter;
  logic signed [dtt_pkg::DelayW-1:0] next_delay;
  logic                          match_found;
  logic                          last;
  modport source (output valid, kind, out_waiter, next_delay, match_found, last,
                  input ready);
  modport sink (input valid, kind, out_waiter, next_delay, match_found, last,
                output ready);
endinterface

>>> hdl/dtt_front.sv
// dtt_front: accepts requests, precomputes the saturated deadline, queues commands.
// Depends on dtt_pkg and dtt_if.
module dtt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  dtt_req_if.sink          req,
  output dtt_pkg::cmd_t    cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i
);
  import dtt_pkg::*;

  cmd_t            fifo_q [QueueDepth];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  cmd_t            cmd_new;
  logic [TimeW:0]  sum;
  logic            push, pop;

  always_comb begin
    sum = {1'b0, req.now_ms} + {{(TimeW+1-DurW){1'b0}}, req.duration_ms[DurW-1:0]};
    cmd_new.action   = action_e'(req.action);
    cmd_new.now_ms   = req.now_ms;
    cmd_new.dur_pos  = (req.duration_ms > 0);
    cmd_new.deadline = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
    cmd_new.waiter   = req.waiter_id;
  end

  assign req.ready   = (cnt_q != 2'(QueueDepth));
  assign push        = req.valid && req.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QueueDepth)) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(QueueDepth) |-> !push) else $error("push while full");
  a_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 2'd1) else $error("count slip");
`endif
endmodule

>>> hdl/dtt_engine.sv
// dtt_engine: timer table and sequencer; scans one entry per cycle unless rsp stalls.
// Depends on dtt_pkg and dtt_if.
module dtt_engine #(
  parameter int unsigned Depth = dtt_pkg::DefaultDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dtt_pkg::cmd_t  cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  dtt_rsp_if.source      rsp
);
  import dtt_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [TimeW-1:0]   dl_q  [Depth];
  logic [WaiterW-1:0] wt_q  [Depth];
  logic [Depth-1:0]   act_q, act_d;
  logic [CntW-1:0]    count_q, count_d;

  eng_state_e         state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic               any_q, any_d;
  logic [TimeW-1:0]   best_q, best_d;
  logic               fired_q, fired_d;
  logic [WaiterW-1:0] pend_q, pend_d;   // fired handle held back until the next one is known

  // output register
  logic               ov_q, ov_d;
  kind_e              okind_q, okind_d;
  logic [WaiterW-1:0] owt_q, owt_d;
  logic [DelayW-1:0]  odl_q, odl_d;
  logic               omatch_q, omatch_d;
  logic               olast_q, olast_d;

  // table write port
  logic               we;
  logic [IdxW-1:0]    wa;
  logic [TimeW-1:0]   wdl;
  logic [WaiterW-1:0] wwt;

  logic [IdxW-1:0]    cur, tail;
  logic [TimeW-1:0]   cur_dl, remain_ms;
  logic               out_free;

  assign cur      = idx_q[IdxW-1:0];
  assign tail     = IdxW'(count_q - CntW'(1));
  assign cur_dl   = dl_q[cur];
  assign remain_ms = (cur_dl > cmd_q.now_ms) ? cur_dl - cmd_q.now_ms : '0;
  assign out_free = !ov_q || rsp.ready;
  assign cmd_ready_o = (state_q == ST_IDLE);

  assign rsp.valid       = ov_q;
  assign rsp.kind        = okind_q;
  assign rsp.out_waiter  = owt_q;
  assign rsp.next_delay  = odl_q;
  assign rsp.match_found = omatch_q;
  assign rsp.last        = olast_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      dl_q[wa] <= wdl;
      wt_q[wa] <= wwt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
      idx_q   <= '0;
      any_q   <= 1'b0;
      fired_q <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
      any_q   <= any_d;
      fired_q <= fired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    best_q   <= best_d;
    pend_q   <= pend_d;
    okind_q  <= okind_d;
    owt_q    <= owt_d;
    odl_q    <= odl_d;
    omatch_q <= omatch_d;
    olast_q  <= olast_d;
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    any_d    = any_q;
    best_d   = best_q;
    fired_d  = fired_q;
    pend_d   = pend_q;
    act_d    = act_q;
    count_d  = count_q;
    ov_d     = ov_q && !rsp.ready;
    okind_d  = okind_q;
    owt_d    = owt_q;
    odl_d    = odl_q;
    omatch_d = omatch_q;
    olast_d  = olast_q;
    we       = 1'b0;
    wa       = cur;
    wdl      = dl_q[tail];
    wwt      = wt_q[tail];

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          idx_d   = '0;
          any_d   = 1'b0;
          fired_d = 1'b0;
          unique case (cmd_i.action)
            ACT_ADD:    state_d = ST_ADD;
            ACT_CANCEL: state_d = ST_CANCEL;
            ACT_FIRE:   state_d = ST_FIRE;
            default:    state_d = ST_QUERY;
          endcase
        end
      end
      ST_ADD: begin
        if (out_free) begin
          ov_d = 1'b1; owt_d = cmd_q.waiter; odl_d = '0; omatch_d = 1'b0;
          olast_d = 1'b1;
          if (!cmd_q.dur_pos) begin
            okind_d = KIND_IMMEDIATE;
          end else if (count_q == CntW'(Depth)) begin
            okind_d = KIND_FULL;
          end else begin
            okind_d = KIND_ARMED;
            we  = 1'b1;
            wa  = IdxW'(count_q);
            wdl = cmd_q.deadline;
            wwt = cmd_q.waiter;
            act_d[IdxW'(count_q)] = 1'b1;
            count_d = count_q + CntW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      ST_CANCEL: begin
        if (idx_q < count_q && !(act_q[cur] && wt_q[cur] == cmd_q.waiter)) begin
          idx_d = idx_q + CntW'(1);
        end else if (out_free) begin
          if (idx_q < count_q) act_d[cur] = 1'b0;
          ov_d = 1'b1; okind_d = KIND_CANCELLED; owt_d = cmd_q.waiter;
          odl_d = '0; omatch_d = (idx_q < count_q); olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FIRE: begin
        if (idx_q < count_q) begin
          if (act_q[cur] && cur_dl > cmd_q.now_ms) begin
            idx_d = idx_q + CntW'(1);
          end else if (!act_q[cur] || !fired_q || out_free) begin
            // swap-remove: tail moves into this slot, which is tested again
            if (act_q[cur]) begin
              // a newer due handle exists, so the held one is not the last
              if (fired_q) begin
                ov_d = 1'b1; okind_d = KIND_FIRED; owt_d = pend_q;
                odl_d = '0; omatch_d = 1'b0; olast_d = 1'b0;
              end
              pend_d  = wt_q[cur];
              fired_d = 1'b1;
            end
            we = 1'b1;
            act_d[cur]  = act_q[tail];
            act_d[tail] = 1'b0;
            count_d = count_q - CntW'(1);
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_QUERY: begin
        if (idx_q < count_q) begin
          if (act_q[cur] && (!any_q || remain_ms < best_q)) begin
            best_d = remain_ms;
            any_d  = 1'b1;
          end
          idx_d = idx_q + CntW'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // closing result: held-back fired handle, nothing due, or the query answer
        if (out_free) begin
          ov_d = 1'b1; owt_d = '0; odl_d = '0; omatch_d = 1'b0; olast_d = 1'b1;
          if (cmd_q.action == ACT_FIRE) begin
            if (fired_q) begin
              okind_d = KIND_FIRED; owt_d = pend_q;
            end else begin
              okind_d = KIND_NONE_DUE;
            end
          end else begin
            okind_d = KIND_DELAY;
            odl_d = any_q ? {1'b0, best_q} : {DelayW{1'b1}};
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("count above depth");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !rsp.ready |=> ov_q && $stable(owt_q) && $stable(okind_q))
    else $error("result changed while stalled");
  a_idle_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_add_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD |=> count_q >= $past(count_q)) else $error("add shrank table");
`endif
endmodule

>>> hdl/deadline_timer_table.sv
// Deadline timer table: one-shot timers armed, cancelled, fired and queried.
// Add answers from its single add state; cancel, fire and query first scan the table
// one entry at a time in the scan loop, then give their result.
// Throughput: one request at a time in the engine; a two-entry queue in front takes more.
// Reset (rst_ni low, async): table empty, all active marks clear, queue and output empty.
// Stored deadlines and handles are undefined until written and never read before that.
module deadline_timer_table #(
  parameter int unsigned TABLE_DEPTH = dtt_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtt_req_if.sink   req,
  dtt_rsp_if.source rsp
);
  import dtt_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // front: request queue with deadline precompute
  dtt_front u_front (
    .clk_i, .rst_ni, .req,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  // back: table and scan sequencer
  dtt_engine #(.Depth(TABLE_DEPTH)) u_engine (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .rsp
  );
endmodule
